// ----- hw/rtl/rsi_pkg.sv -----
// Shared types, constants and fixed-point helpers for the ray/sphere
// intersection pipeline. No dependencies.
package rsi_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned RADIUS_W   = 31;
	localparam int unsigned SQRT_STEPS = 32;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
	localparam logic signed [31:0] DIR_ONE       = 32'sd1073741824;
	localparam logic signed [31:0] DIR_MINUS_ONE = -32'sd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} rsi_reg_t;

	typedef logic signed [32:0] rsi_oc_t;
	typedef logic signed [31:0] rsi_dir_t;
	typedef logic signed [35:0] rsi_proj_t;

	typedef struct packed {
		rsi_oc_t   oc_x;
		rsi_oc_t   oc_y;
		rsi_oc_t   oc_z;
		rsi_dir_t  dir_x;
		rsi_dir_t  dir_y;
		rsi_dir_t  dir_z;
		rsi_proj_t proj;
	} rsi_ray_t;

	typedef struct packed {
		logic      miss;
		rsi_proj_t proj;
	} rsi_side_t;

	// Divide a product with a Q1.30 factor by 2^30, truncating toward zero.
	function automatic logic signed [37:0] trunc_q30(input logic signed [67:0] p);
		logic signed [67:0] adj;
		adj = p + (p[67] ? 68'sd1073741823 : 68'sd0);
		return adj[67:30];
	endfunction

	// Clamp a direction component to [-1.0, 1.0] in Q1.30.
	function automatic rsi_dir_t sat_dir(input logic signed [31:0] d);
		rsi_dir_t r;
		if (d > DIR_ONE) begin
			r = DIR_ONE;
		end else if (d < DIR_MINUS_ONE) begin
			r = DIR_MINUS_ONE;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/rsi_ray_if.sv -----
// Ray input channel: valid/ready handshake with origin and direction payload.
// No dependencies.
interface rsi_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

// ----- hw/rtl/rsi_hit_if.sv -----
// Hit result channel: valid/ready handshake with hit flag and distance.
// No dependencies.
interface rsi_hit_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] hit_distance;

	modport source (output valid, hit, hit_distance, input ready);
	modport sink (input valid, hit, hit_distance, output ready);
endinterface

// ----- hw/rtl/ray_sphere_intersection_top.sv -----
// Ray/sphere intersection top level: config registers, pipeline, output register.
// Path from transaction on ray to result valid on res:
// 3 projection stages, 4 perpendicular stages, 32 square-root stages, 1 output.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits.
// Reset (arst_n low, asynchronous): all valid bits clear, center 0, radius 1.0.
// Depends on rsi_pkg, rsi_ray_if, rsi_hit_if, rsi_proj, rsi_perp, rsi_sqrt.
module ray_sphere_intersection_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	rsi_ray_if.sink                         ray,
	rsi_hit_if.source                       res
);
	import rsi_pkg::*;

	// Sphere configuration; the user must write it only while the pipeline is idle (not enforced here).
	logic signed [31:0]  center_x_q, center_y_q, center_z_q;
	logic [RADIUS_W-1:0] radius_q;

	// Global advance: every stage moves when the output register is free or
	// its transaction completes this cycle.
	logic en;

	logic      proj_valid;
	rsi_ray_t  proj_ray;
	logic      perp_valid;
	logic [61:0] perp_diff;
	rsi_side_t perp_side;
	logic      sqrt_valid;
	logic [30:0] sqrt_root;
	rsi_side_t sqrt_side;

	logic signed [36:0] t_near, t_far, t_sel;
	logic        hit_d;
	logic [31:0] dist_d;

	logic        out_valid_q;
	logic        out_hit_q;
	logic [31:0] out_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (rsi_reg_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				REG_CENTER_Z: center_z_q <= cfg_wdata;
				REG_RADIUS:   radius_q   <= cfg_wdata[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	assign en        = !out_valid_q || res.ready;
	assign ray.ready = en;

	rsi_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ray.valid),
		.origin_x  (ray.origin_x),
		.origin_y  (ray.origin_y),
		.origin_z  (ray.origin_z),
		.dir_x     (ray.dir_x),
		.dir_y     (ray.dir_y),
		.dir_z     (ray.dir_z),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.center_z  (center_z_q),
		.out_valid (proj_valid),
		.out_ray   (proj_ray)
	);

	rsi_perp u_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (proj_valid),
		.in_ray    (proj_ray),
		.radius    (radius_q),
		.out_valid (perp_valid),
		.out_diff  (perp_diff),
		.out_side  (perp_side)
	);

	rsi_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (perp_valid),
		.in_rad    (perp_diff),
		.in_side   (perp_side),
		.out_valid (sqrt_valid),
		.out_root  (sqrt_root),
		.out_side  (sqrt_side)
	);

	// Pick the nearest non-negative root: near root first, else far root
	// (origin inside the sphere), else the sphere lies behind the ray.
	always_comb begin
		t_near = 37'(sqrt_side.proj) - $signed({6'd0, sqrt_root});
		t_far  = 37'(sqrt_side.proj) + $signed({6'd0, sqrt_root});
		t_sel  = !t_near[36] ? t_near : t_far;
		hit_d  = !sqrt_side.miss && (!t_near[36] || !t_far[36]);
		if (!hit_d) begin
			dist_d = '0;
		end else if (t_sel[35:32] != 4'd0) begin
			dist_d = '1;
		end else begin
			dist_d = t_sel[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sqrt_valid;
		end
	end

	// Hold the result payload while the downstream stalls.
	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q  <= hit_d;
			out_dist_q <= dist_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.hit          = out_hit_q;
	assign res.hit_distance = out_dist_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_hit_q |-> out_dist_q == 32'd0)
		else $error("miss result carries a nonzero distance");

	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sqrt_valid) && $stable(sqrt_root))
		else $error("square-root tail moved during a stall");

	a_rise_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(en) && $past(sqrt_valid))
		else $error("result appeared without an advancing stage");

	a_miss_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		en && sqrt_valid && sqrt_side.miss |=> !out_hit_q)
		else $error("missed ray reported as hit");
`endif
endmodule

// ----- hw/rtl/rsi_proj.sv -----
// Stages 1-3: origin-to-center vector, direction clamp, projection onto the ray.
// Depends on rsi_pkg.
module rsi_proj (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	output logic               out_valid,
	output rsi_pkg::rsi_ray_t  out_ray
);
	import rsi_pkg::*;

	logic     vld_s1, vld_s2, vld_s3;
	rsi_oc_t  oc_x_s1, oc_y_s1, oc_z_s1, oc_x_s2, oc_y_s2, oc_z_s2;
	rsi_oc_t  oc_x_s3, oc_y_s3, oc_z_s3;
	rsi_dir_t dir_x_s1, dir_y_s1, dir_z_s1, dir_x_s2, dir_y_s2, dir_z_s2;
	rsi_dir_t dir_x_s3, dir_y_s3, dir_z_s3;
	logic signed [64:0] prod_x_s2, prod_y_s2, prod_z_s2;
	rsi_proj_t proj_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oc_x_s1  <= {center_x[31], center_x} - {origin_x[31], origin_x};
			oc_y_s1  <= {center_y[31], center_y} - {origin_y[31], origin_y};
			oc_z_s1  <= {center_z[31], center_z} - {origin_z[31], origin_z};
			dir_x_s1 <= sat_dir(dir_x);
			dir_y_s1 <= sat_dir(dir_y);
			dir_z_s1 <= sat_dir(dir_z);

			prod_x_s2 <= oc_x_s1 * dir_x_s1;
			prod_y_s2 <= oc_y_s1 * dir_y_s1;
			prod_z_s2 <= oc_z_s1 * dir_z_s1;
			oc_x_s2   <= oc_x_s1;
			oc_y_s2   <= oc_y_s1;
			oc_z_s2   <= oc_z_s1;
			dir_x_s2  <= dir_x_s1;
			dir_y_s2  <= dir_y_s1;
			dir_z_s2  <= dir_z_s1;

			proj_s3  <= 36'(trunc_q30(68'(prod_x_s2))) + 36'(trunc_q30(68'(prod_y_s2)))
				+ 36'(trunc_q30(68'(prod_z_s2)));
			oc_x_s3  <= oc_x_s2;
			oc_y_s3  <= oc_y_s2;
			oc_z_s3  <= oc_z_s2;
			dir_x_s3 <= dir_x_s2;
			dir_y_s3 <= dir_y_s2;
			dir_z_s3 <= dir_z_s2;
		end
	end

	assign out_valid     = vld_s3;
	assign out_ray.oc_x  = oc_x_s3;
	assign out_ray.oc_y  = oc_y_s3;
	assign out_ray.oc_z  = oc_z_s3;
	assign out_ray.dir_x = dir_x_s3;
	assign out_ray.dir_y = dir_y_s3;
	assign out_ray.dir_z = dir_z_s3;
	assign out_ray.proj  = proj_s3;
endmodule

// ----- hw/rtl/rsi_perp.sv -----
// Stages 4-7: foot of the perpendicular, perpendicular distance squared,
// miss test and r^2 - d^2. Depends on rsi_pkg.
module rsi_perp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  rsi_pkg::rsi_ray_t              in_ray,
	input  logic [rsi_pkg::RADIUS_W-1:0]   radius,
	output logic                           out_valid,
	output logic [61:0]                    out_diff,
	output rsi_pkg::rsi_side_t             out_side
);
	import rsi_pkg::*;

	logic      vld_s4, vld_s5, vld_s6, vld_s7;
	rsi_ray_t  ray_s4;
	logic signed [67:0] q_x_s4, q_y_s4, q_z_s4;
	logic signed [37:0] perp_x, perp_y, perp_z;
	logic [37:0] mag_x, mag_y, mag_z;
	logic [RADIUS_W-1:0] m_x_s5, m_y_s5, m_z_s5;
	logic      miss_s5, miss_s6, miss_s7;
	rsi_proj_t proj_s5, proj_s6, proj_s7;
	logic [61:0] sq_x_s6, sq_y_s6, sq_z_s6, r2_s6, diff_s7;
	logic [63:0] d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_comb begin
		perp_x = 38'(ray_s4.oc_x) - trunc_q30(q_x_s4);
		perp_y = 38'(ray_s4.oc_y) - trunc_q30(q_y_s4);
		perp_z = 38'(ray_s4.oc_z) - trunc_q30(q_z_s4);
		mag_x  = perp_x[37] ? 38'(-perp_x) : 38'(perp_x);
		mag_y  = perp_y[37] ? 38'(-perp_y) : 38'(perp_y);
		mag_z  = perp_z[37] ? 38'(-perp_z) : 38'(perp_z);
		d2     = {2'b00, sq_x_s6} + {2'b00, sq_y_s6} + {2'b00, sq_z_s6};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_x_s4 <= in_ray.proj * in_ray.dir_x;
			q_y_s4 <= in_ray.proj * in_ray.dir_y;
			q_z_s4 <= in_ray.proj * in_ray.dir_z;
			ray_s4 <= in_ray;

			// Any single component beyond the radius is a miss; this also
			// keeps the squares below narrow.
			miss_s5 <= (mag_x > {7'd0, radius}) || (mag_y > {7'd0, radius})
				|| (mag_z > {7'd0, radius});
			m_x_s5  <= mag_x[RADIUS_W-1:0];
			m_y_s5  <= mag_y[RADIUS_W-1:0];
			m_z_s5  <= mag_z[RADIUS_W-1:0];
			proj_s5 <= ray_s4.proj;

			sq_x_s6 <= m_x_s5 * m_x_s5;
			sq_y_s6 <= m_y_s5 * m_y_s5;
			sq_z_s6 <= m_z_s5 * m_z_s5;
			r2_s6   <= radius * radius;
			miss_s6 <= miss_s5;
			proj_s6 <= proj_s5;

			miss_s7 <= miss_s6 || (d2 > {2'b00, r2_s6});
			diff_s7 <= r2_s6 - d2[61:0];
			proj_s7 <= proj_s6;
		end
	end

	assign out_valid     = vld_s7;
	assign out_diff      = diff_s7;
	assign out_side.miss = miss_s7;
	assign out_side.proj = proj_s7;
endmodule

// ----- hw/rtl/rsi_sqrt.sv -----
// Pipelined integer square root, one restoring step per register stage,
// with a side payload carried alongside. Depends on rsi_pkg.
module rsi_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [61:0]        in_rad,
	input  rsi_pkg::rsi_side_t in_side,
	output logic               out_valid,
	output logic [30:0]        out_root,
	output rsi_pkg::rsi_side_t out_side
);
	import rsi_pkg::*;

	logic        vld_s  [SQRT_STEPS+1];
	logic [63:0] rem_s  [SQRT_STEPS+1];
	logic [63:0] root_s [SQRT_STEPS+1];
	rsi_side_t   side_s [SQRT_STEPS+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = {2'b00, in_rad};
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic        take;

		always_comb begin
			trial = root_s[k] + STEP_BIT;
			take  = rem_s[k] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] >> 1) + STEP_BIT : root_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign out_root  = root_s[SQRT_STEPS][30:0];
	assign out_side  = side_s[SQRT_STEPS];
endmodule

// ----- test/ray_sphere_intersection_top_tb.sv -----
// Self-checking testbench for ray_sphere_intersection_top: streams rays through
// the ray channel and checks every hit result against an in-bench predictor.
// Depends on rsi_pkg, rsi_ray_if, rsi_hit_if and the RTL of the block.
module ray_sphere_intersection_top_tb;
	import rsi_pkg::*;

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [31:0] dx, dy, dz;
	} ray_item_t;

	typedef struct {
		logic        hit;
		logic [31:0] hit_dist;
	} hit_item_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int HOLD_CYCLES    = 200;
	localparam longint Q30_ONE    = 64'sd1073741824;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rsi_ray_if ray ();
	rsi_hit_if res ();

	ray_sphere_intersection_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.ray      (ray.sink),
		.res      (res.source)
	);

	// Predictor's copy of the sphere registers
	longint sph_cx, sph_cy, sph_cz, sph_r;

	ray_item_t ray_q[$];   // rays waiting for the driver
	hit_item_t hit_q[$];   // predicted hits, oldest first

	int n_pushed, n_sent, n_rcv, n_err;
	int n_hits, n_sat;
	int quiet_cycles;
	int hold_cnt;
	bit hold_done;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Product with a Q1.30 factor, divided by 2^30 and truncated toward zero
	function automatic longint q30_scale(input longint a, input longint b);
		logic signed [127:0] wa, wb, prod, mag;
		wa = a;
		wb = b;
		prod = wa * wb;
		mag = prod[127] ? -prod : prod;
		mag = mag >>> 30;
		return prod[127] ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp_dir(input logic signed [31:0] d);
		longint v;
		v = d;
		if (v > Q30_ONE) v = Q30_ONE;
		if (v < -Q30_ONE) v = -Q30_ONE;
		return v;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] acc, step;
		acc = 0;
		step = 64'd1 << 62;
		while (step > v) step = step >> 2;
		while (step != 0) begin
			if (v >= acc + step) begin
				v = v - (acc + step);
				acc = (acc >> 1) + step;
			end else begin
				acc = acc >> 1;
			end
			step = step >> 2;
		end
		return acc;
	endfunction

	// Expected hit for one ray under the current sphere
	function automatic hit_item_t trace_sphere(input ray_item_t r);
		longint oc[3], dv[3], perp, proj, t_near, t_far, t;
		logic [63:0] mag, d2, r2, delta;
		hit_item_t h;
		h.hit = 1'b0;
		h.hit_dist = '0;
		oc[0] = sph_cx - longint'(r.ox);
		oc[1] = sph_cy - longint'(r.oy);
		oc[2] = sph_cz - longint'(r.oz);
		dv[0] = clamp_dir(r.dx);
		dv[1] = clamp_dir(r.dy);
		dv[2] = clamp_dir(r.dz);
		proj = 0;
		for (int i = 0; i < 3; i++) proj += q30_scale(oc[i], dv[i]);
		d2 = 0;
		for (int i = 0; i < 3; i++) begin
			perp = oc[i] - q30_scale(proj, dv[i]);
			mag = perp < 0 ? -perp : perp;
			// far perpendicular: miss before squaring
			if (mag > sph_r) return h;
			d2 += mag * mag;
		end
		r2 = sph_r * sph_r;
		if (d2 > r2) return h;
		delta = root_floor(r2 - d2);
		t_near = proj - longint'(delta);
		t_far = proj + longint'(delta);
		// origin inside: near root negative, take the far one
		if (t_near >= 0) t = t_near;
		else if (t_far >= 0) t = t_far;
		else return h;
		h.hit = 1'b1;
		h.hit_dist = (t > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
		return h;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t on result %0d: %s got %0h want %0h",
			$realtime, n_rcv, what, got, want);
		n_err++;
	endtask

	function automatic bit idle_now();
		// long stretch with no idling on either side
		if (n_sent >= 600 && n_sent < 800) return 1'b0;
		return $urandom_range(99) < 18;
	endfunction

	// Ray driver: load the next ray once the current transaction is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray.valid <= 1'b0;
		end else if (!ray.valid || ray.ready) begin
			if (ray_q.size() != 0 && !idle_now()) begin
				ray_item_t r;
				r = ray_q.pop_front();
				ray.valid <= 1'b1;
				ray.origin_x <= r.ox;
				ray.origin_y <= r.oy;
				ray.origin_z <= r.oz;
				ray.dir_x <= r.dx;
				ray.dir_y <= r.dy;
				ray.dir_z <= r.dz;
			end else begin
				ray.valid <= 1'b0;
			end
		end
	end

	// Input monitor: predict at the accepting edge with the current registers
	always @(posedge clk) begin
		if (arst_n && ray.valid && ray.ready) begin
			ray_item_t r;
			r.ox = ray.origin_x;
			r.oy = ray.origin_y;
			r.oz = ray.origin_z;
			r.dx = ray.dir_x;
			r.dy = ray.dir_y;
			r.dz = ray.dir_z;
			hit_q.push_back(trace_sphere(r));
			n_sent++;
		end
	end

	// Result sink: random stalls, plus one long hold-off to back up the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			res.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && n_sent >= 300) begin
			res.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			res.ready <= !idle_now();
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (hit_q.size() == 0) begin
				report_mismatch("unexpected transaction", res.hit, 0);
			end else begin
				hit_item_t h;
				h = hit_q.pop_front();
				if (res.hit !== h.hit) report_mismatch("hit", res.hit, h.hit);
				if (res.hit_distance !== h.hit_dist)
					report_mismatch("hit_distance", res.hit_distance, h.hit_dist);
				if (h.hit) n_hits++;
				if (h.hit && h.hit_dist == 32'hFFFFFFFF) n_sat++;
			end
			n_rcv++;
		end
	end

	// Watchdog: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (ray.valid && ray.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
				$display("ray_sphere_intersection_top_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input rsi_reg_t idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_CENTER_X: sph_cx = longint'(signed'(data));
			REG_CENTER_Y: sph_cy = longint'(signed'(data));
			REG_CENTER_Z: sph_cz = longint'(signed'(data));
			REG_RADIUS:   sph_r = longint'(data[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_sphere(input logic [31:0] cx, cy, cz, rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, rad);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
		ray_item_t r;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		ray_q.push_back(r);
		n_pushed++;
	endtask

	function automatic logic [31:0] to_coord(input real v);
		if (v > 2147483647.0) v = 2147483647.0;
		if (v < -2147483648.0) v = -2147483648.0;
		return 32'(longint'(v));
	endfunction

	function automatic real jitter(input real span);
		return (real'($urandom_range(2000)) - 1000.0) / 1000.0 * span;
	endfunction

	// Ray launched near the sphere and pointed roughly at it
	task automatic push_aimed_ray();
		real rr, o[3], d[3], len;
		rr = (sph_r < 65536) ? 65536.0 : real'(sph_r);
		o[0] = real'(sph_cx) + jitter(4.0 * rr);
		o[1] = real'(sph_cy) + jitter(4.0 * rr);
		o[2] = real'(sph_cz) + jitter(4.0 * rr);
		d[0] = real'(sph_cx) + jitter(1.2 * rr) - o[0];
		d[1] = real'(sph_cy) + jitter(1.2 * rr) - o[1];
		d[2] = real'(sph_cz) + jitter(1.2 * rr) - o[2];
		len = $sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
		if (len < 1.0) begin
			d[0] = 1.0; d[1] = 0.0; d[2] = 0.0; len = 1.0;
		end
		push_ray(to_coord(o[0]), to_coord(o[1]), to_coord(o[2]),
			to_coord(d[0] / len * 1073741824.0), to_coord(d[1] / len * 1073741824.0),
			to_coord(d[2] / len * 1073741824.0));
	endtask

	task automatic push_random_rays(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				push_aimed_ray();
			end else if (pick < 85) begin
				// raw bits everywhere, directions often out of range
				push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				push_ray($urandom, $urandom, $urandom,
					32'($urandom_range(2 * 1073741824) - 1073741824),
					32'($urandom_range(2 * 1073741824) - 1073741824),
					32'($urandom_range(2 * 1073741824) - 1073741824));
			end
		end
	endtask

	// Wait for every prediction to be matched, then let the pipe settle
	task automatic drain();
		while (n_rcv < n_pushed) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] one, ten;
		one = 32'd65536;
		ten = 32'd655360;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_wdata = '0;
		ray.valid = 1'b0;
		ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
		ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
		res.ready = 1'b0;
		sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = RADIUS_RESET;
		n_pushed = 0; n_sent = 0; n_rcv = 0; n_err = 0;
		n_hits = 0; n_sat = 0; quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset sphere: unit sphere at the origin
		push_ray(-ten, 0, 0, DIR_ONE, 0, 0);
		push_ray(0, 0, 0, 0, DIR_ONE, 0);
		drain();

		// Sphere at z = 10, radius 1
		set_sphere(0, 0, ten, one);
		push_ray(0, 0, 0, 0, 0, DIR_ONE);                 // straight hit at 9
		push_ray(one, 0, 0, 0, 0, DIR_ONE);               // tangent
		push_ray(0, 0, ten, DIR_ONE, 0, 0);               // origin at the center
		push_ray(0, 0, ten + one / 2, 0, 0, DIR_MINUS_ONE); // inside, going back
		push_ray(0, 0, 0, 0, 0, DIR_MINUS_ONE);           // sphere behind
		push_ray(5 * one, 0, 0, 0, 0, DIR_ONE);           // far perpendicular
		push_ray(0, 0, 0, 0, 0, 32'h7FFFFFFF);            // direction clamped high
		push_ray(0, 0, 2 * ten, 0, 0, 32'h80000000);      // direction clamped low
		push_ray(0, 0, 0, 0, 0, 32'd536870912);           // half-length direction
		push_ray(0, 0, 0, 0, 0, 0);                       // zero direction
		push_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, DIR_MINUS_ONE, 0, 0);
		push_ray(32'h80000000, 32'h80000000, 32'h80000000, DIR_ONE, DIR_ONE, DIR_ONE);
		push_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF);
		push_random_rays(160);
		drain();

		// Extreme corner center: long diagonal rays saturate the distance
		set_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, one);
		push_ray(32'h80000000, 32'h80000000, 32'h80000000,
			32'd619925131, 32'd619925131, 32'd619925131);
		push_ray(32'h80000000, 32'h80000000, 32'h80000000, DIR_ONE, 0, 0);
		push_random_rays(170);
		drain();

		// Opposite corner, zero radius: only exact hits count
		set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 0);
		push_ray(32'h80000000, 32'h80000000, 32'h80000000, DIR_ONE, 0, 0);
		push_ray(32'h80000000, 32'h80000000, 32'h80000000 + ten, 0, 0, DIR_MINUS_ONE);
		push_random_rays(170);
		drain();

		// Largest radius; bit 31 of the write data must be dropped
		set_sphere(0, 0, 0, 32'hFFFFFFFF);
		push_ray(0, 0, 0, DIR_ONE, 0, 0);
		push_random_rays(170);
		drain();

		// Random spheres of moderate size
		for (int p = 0; p < 4; p++) begin
			set_sphere(32'($urandom_range(1 << 25) - (1 << 24)),
				32'($urandom_range(1 << 25) - (1 << 24)),
				32'($urandom_range(1 << 25) - (1 << 24)),
				$urandom_range(1 << 22));
			push_random_rays(175);
			drain();
		end

		if (hit_q.size() != 0) report_mismatch("results left over", hit_q.size(), 0);
		$display("covered %0d rays over 9 sphere settings: %0d hits, %0d saturated",
			n_sent, n_hits, n_sat);
		$display("included a %0d-cycle result hold-off and %0d mismatches",
			HOLD_CYCLES, n_err);
		if (n_err == 0) begin
			$display("ray_sphere_intersection_top_tb: PASS");
		end else begin
			$display("ray_sphere_intersection_top_tb: FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_ray_if.sv
hw/rtl/rsi_hit_if.sv
hw/rtl/rsi_proj.sv
hw/rtl/rsi_perp.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/ray_sphere_intersection_top.sv
test/ray_sphere_intersection_top_tb.sv
